// File: src/rce_pkg.sv
`timescale 1ns / 1ps
// rce_pkg: word types, register map and crc helper functions for the reflected crc engine
// depends on nothing; used by reflected_crc_engine_unit

package rce_pkg;

	localparam int unsigned CrcWidth  = 32;
	localparam int unsigned ByteWidth = 8;
	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;

	localparam logic [CrcWidth-1:0] PolyResetValue = 32'h0000_8408;

	typedef enum logic [1:0] {
		REG_POLY_REFLECTED = 2'd0,
		REG_PRESET_ONES    = 2'd1,
		REG_MSB_FIRST      = 2'd2,
		REG_UNMAPPED       = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [ByteWidth-1:0] data_byte;
		logic                 last_of_message;
	} byte_word_t;

	typedef struct packed {
		logic [CrcWidth-1:0] crc_value;
		logic [CrcWidth-1:0] crc_inverted;
		logic [CrcWidth-1:0] crc_reversed;
		logic [CrcWidth-1:0] crc_reversed_inverted;
		logic                end_of_message;
	} crc_word_t;

	function automatic logic [ByteWidth-1:0] reverse_byte(input logic [ByteWidth-1:0] v);
		logic [ByteWidth-1:0] r;
		for (int i = 0; i < ByteWidth; i++) begin
			r[i] = v[ByteWidth-1-i];
		end
		return r;
	endfunction

	function automatic logic [CrcWidth-1:0] reverse_crc(input logic [CrcWidth-1:0] v);
		logic [CrcWidth-1:0] r;
		for (int i = 0; i < CrcWidth; i++) begin
			r[i] = v[CrcWidth-1-i];
		end
		return r;
	endfunction

	// ones from bit 0 up to the highest set bit of the polynomial
	function automatic logic [CrcWidth-1:0] preset_mask(input logic [CrcWidth-1:0] poly);
		logic [CrcWidth-1:0] m;
		m = poly;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		return m;
	endfunction

	// eight shift-and-xor steps, byte enters lsb first
	function automatic logic [CrcWidth-1:0] crc_update(
		input logic [CrcWidth-1:0]  crc_in,
		input logic [ByteWidth-1:0] b,
		input logic [CrcWidth-1:0]  poly
	);
		logic [CrcWidth-1:0] c;
		logic                fb;
		c = crc_in;
		for (int k = 0; k < ByteWidth; k++) begin
			fb = b[k] ^ c[0];
			c  = c >> 1;
			if (fb) begin
				c = c ^ poly;
			end
		end
		return c;
	endfunction

endpackage

// File: src/reflected_crc_engine_unit.sv
`timescale 1ns / 1ps
// reflected_crc_engine_unit: byte-wide reflected crc with configurable polynomial, apb registers
// depends on rce_pkg
//
// channel   direction  handshake                 word
// byte      sink       byte_valid / byte_stall   rce_pkg::byte_word_t (data_byte, last_of_message)
// crc       source     crc_valid / crc_stall     rce_pkg::crc_word_t (four crc forms, end_of_message)
// apb       sink       psel / penable / pready   poly_reflected, preset_ones, msb_first
//
// one byte per cycle unless the crc side stalls; a byte's crc word is valid after acceptance
// (input register, then the eight unrolled xor steps into the result register)
// reset clears the valids, the running crc and the message flag; no clearing pass is needed
// a stall on the crc side holds the result register and, once the input register is full,
// stalls the byte side in the same cycle

module reflected_crc_engine_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               byte_valid,
	output logic                               byte_stall,
	input  rce_pkg::byte_word_t                byte_word,
	output logic                               crc_valid,
	input  logic                               crc_stall,
	output rce_pkg::crc_word_t                 crc_word,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rce_pkg::AddrWidth-1:0]      paddr,
	input  logic [rce_pkg::DataWidth-1:0]      pwdata,
	output logic [rce_pkg::DataWidth-1:0]      prdata,
	output logic                               pready
);
	import rce_pkg::*;

	logic [CrcWidth-1:0]  poly_q;
	logic                 preset_ones_q;
	logic                 msb_first_q;
	reg_index_t           reg_sel;

	logic                 valid_s1;
	byte_word_t           word_s1;
	logic                 valid_s2;
	crc_word_t            word_s2;
	logic [CrcWidth-1:0]  crc_q;
	logic                 open_q;

	logic                 adv_s1;
	logic                 load_s1;
	logic [ByteWidth-1:0] data_in;
	logic [CrcWidth-1:0]  crc_start;
	logic [CrcWidth-1:0]  crc_next;
	logic [CrcWidth-1:0]  crc_rev;

	// register file
	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[AddrWidth-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q        <= PolyResetValue;
			preset_ones_q <= 1'b0;
			msb_first_q   <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_POLY_REFLECTED: poly_q        <= pwdata[CrcWidth-1:0];
				REG_PRESET_ONES:    preset_ones_q <= pwdata[0];
				REG_MSB_FIRST:      msb_first_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_POLY_REFLECTED: prdata = poly_q;
			REG_PRESET_ONES:    prdata = {{(DataWidth-1){1'b0}}, preset_ones_q};
			REG_MSB_FIRST:      prdata = {{(DataWidth-1){1'b0}}, msb_first_q};
			default:            prdata = '0;
		endcase
	end

	// handshake
	assign adv_s1     = valid_s1 && (!valid_s2 || !crc_stall);
	assign byte_stall = valid_s1 && !adv_s1;
	assign load_s1    = byte_valid && !byte_stall;

	// crc datapath
	assign data_in   = msb_first_q ? reverse_byte(word_s1.data_byte) : word_s1.data_byte;
	assign crc_start = open_q ? crc_q : (preset_ones_q ? preset_mask(poly_q) : '0);
	assign crc_next  = crc_update(crc_start, data_in, poly_q);
	assign crc_rev   = reverse_crc(crc_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			crc_q    <= '0;
			open_q   <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				crc_q    <= crc_next;
				open_q   <= !word_s1.last_of_message;
			end else if (!crc_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1 <= byte_word;
		end
		if (adv_s1) begin
			word_s2.crc_value             <= crc_next;
			word_s2.crc_inverted          <= ~crc_next;
			word_s2.crc_reversed          <= crc_rev;
			word_s2.crc_reversed_inverted <= ~crc_rev;
			word_s2.end_of_message        <= word_s1.last_of_message;
		end
	end

	assign crc_valid = valid_s2;
	assign crc_word  = word_s2;

	// checks
	a_last_closes_message: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && word_s1.last_of_message |=> !open_q)
		else $error("message still open after last word");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> crc_valid && (crc_word.crc_value == crc_q))
		else $error("result word disagrees with running crc");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		crc_valid && !crc_stall && !valid_s1 |=> !crc_valid)
		else $error("result word repeated");

	a_input_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(word_s1))
		else $error("input register lost a held word");

endmodule
